[rtl/core/ptet_pkg.sv]
// Shared types and constants of the periodic timer event table.
`default_nettype none

package ptet_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 5;

  // Fire limit per process transaction and time scale
  localparam int unsigned FIRE_CAP  = 16;
  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned PROD_W    = 26;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch a new input transaction
    logic scan_begin;  // restart the slot scan
    logic scan_issue;  // read the slot at the scan address
    logic emit;        // deliver the scan result
    logic emit_final;  // deliver the process count result
  } ptet_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;    // scan address is the last slot
    logic is_fire;      // scan result is a fired event
    logic cap_reached;  // this fire reaches the fire limit
  } ptet_sts_t;

endpackage

`default_nettype wire

[rtl/core/ptet_dp.sv]
// Datapath of the timer table: slot storage, scan compare and result registers.
`default_nettype none

module ptet_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ptet_pkg::ptet_cmd_t             cmd_i,
  output ptet_pkg::ptet_sts_t                  sts_o,
  input  wire logic [ptet_pkg::CMD_W-1:0]      in_command_i,
  input  wire logic [ptet_pkg::TIME_W-1:0]     in_now_us_i,
  input  wire logic [ptet_pkg::MS_W-1:0]       in_delay_ms_i,
  input  wire logic [ptet_pkg::MS_W-1:0]       in_period_ms_i,
  output logic [ptet_pkg::STATUS_W-1:0]        out_status_o,
  output logic [ptet_pkg::ID_W-1:0]            out_event_id_o,
  output logic [ptet_pkg::TIME_W-1:0]          out_wait_us_o,
  output logic [ptet_pkg::CNT_W-1:0]           out_fired_count_o,
  output logic                                 out_is_fire_o,
  output logic                                 out_last_o
);
  import ptet_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Saturating due time: now plus milliseconds scaled to microseconds
  function automatic logic [TIME_W-1:0] due_after(input logic [TIME_W-1:0] now,
                                                  input logic [MS_W-1:0]   ms);
    logic [PROD_W-1:0] prod;
    logic [TIME_W:0]   sum;
    prod = PROD_W'(ms) * PROD_W'(US_PER_MS);
    sum  = {1'b0, now} + (TIME_W+1)'(prod);
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  // Latched transaction
  logic [CMD_W-1:0]  cmd_q;
  logic [TIME_W-1:0] now_q;
  logic [MS_W-1:0]   delay_q;
  logic [MS_W-1:0]   period_q;

  // Slot storage
  logic [ID_W-1:0]   id_mem_q  [SLOTS];
  logic [TIME_W-1:0] due_mem_q [SLOTS];
  logic [MS_W-1:0]   per_mem_q [SLOTS];
  logic [SLOTS-1:0]  vld_q;
  logic [SLOTS-1:0]  done_q;
  logic [ID_W-1:0]   next_id_q;

  // Scan address and read stage
  logic [IDX_W-1:0]  addr_q;
  logic              s1_vld_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic [ID_W-1:0]   id_rd_q;
  logic [TIME_W-1:0] due_rd_q;
  logic [MS_W-1:0]   per_rd_q;
  logic              vld_rd_q;
  logic              done_rd_q;

  // Best candidate so far
  logic              best_hit_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [ID_W-1:0]   best_id_q;
  logic [TIME_W-1:0] best_due_q;
  logic [MS_W-1:0]   best_per_q;

  logic [CNT_W-1:0]  cnt_q;

  logic              cand;
  logic              is_create;
  logic              is_process;
  logic              is_query;
  logic              due_we;
  logic [TIME_W-1:0] due_wd;
  logic [TIME_W-1:0] wait_val;

  assign is_create  = (cmd_q == CMD_CREATE);
  assign is_process = (cmd_q == CMD_PROCESS);
  assign is_query   = (cmd_q == CMD_QUERY);

  // Latch the input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= in_command_i;
      now_q    <= in_now_us_i;
      delay_q  <= in_delay_ms_i;
      period_q <= in_period_ms_i;
    end
  end

  // Advance the scan address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.scan_issue;
      if (cmd_i.load || cmd_i.scan_begin) begin
        addr_q <= '0;
      end else if (cmd_i.scan_issue) begin
        addr_q <= addr_q + IDX_W'(1);
      end
    end
  end

  // Read the addressed slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      s1_idx_q  <= addr_q;
      id_rd_q   <= id_mem_q[addr_q];
      due_rd_q  <= due_mem_q[addr_q];
      per_rd_q  <= per_mem_q[addr_q];
      vld_rd_q  <= vld_q[addr_q];
      done_rd_q <= done_q[addr_q];
    end
  end

  // Decide whether the read slot beats the current best
  always_comb begin
    cand = 1'b0;
    case (cmd_q)
      CMD_CREATE:  cand = !vld_rd_q && !best_hit_q;
      CMD_QUERY:   cand = vld_rd_q && (!best_hit_q || (due_rd_q < best_due_q));
      CMD_PROCESS: cand = vld_rd_q && !done_rd_q && (due_rd_q <= now_q) &&
                          (!best_hit_q || (id_rd_q > best_id_q));
      default:     cand = 1'b0;
    endcase
  end

  // Hold the best candidate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_hit_q <= 1'b0;
    end else if (cmd_i.load || cmd_i.scan_begin) begin
      best_hit_q <= 1'b0;
    end else if (s1_vld_q && cand) begin
      best_hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && cand) begin
      best_idx_q <= s1_idx_q;
      best_id_q  <= id_rd_q;
      best_due_q <= due_rd_q;
      best_per_q <= per_rd_q;
    end
  end

  // Slot writes on delivery
  assign due_we = cmd_i.emit && best_hit_q &&
                  (is_create || (is_process && (best_per_q != '0)));
  assign due_wd = due_after(now_q, is_create ? delay_q : best_per_q);

  always_ff @(posedge clk_i) begin
    if (due_we) begin
      due_mem_q[best_idx_q] <= due_wd;
    end
    if (cmd_i.emit && best_hit_q && is_create) begin
      id_mem_q[best_idx_q]  <= next_id_q;
      per_mem_q[best_idx_q] <= period_q;
    end
  end

  // Valid, done, id counter and fire count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      done_q    <= '0;
      next_id_q <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.load) begin
      done_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.emit && best_hit_q) begin
      if (is_create) begin
        vld_q[best_idx_q] <= 1'b1;
        next_id_q         <= next_id_q + ID_W'(1);
      end else if (is_process) begin
        done_q[best_idx_q] <= 1'b1;
        cnt_q              <= cnt_q + CNT_W'(1);
        if (best_per_q == '0) begin
          vld_q[best_idx_q] <= 1'b0;
        end
      end
    end
  end

  // Time until the earliest event, zero once due
  assign wait_val = (now_q >= best_due_q) ? '0 : (best_due_q - now_q);

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit || cmd_i.emit_final) begin
      out_status_o      <= ST_OK;
      out_event_id_o    <= '0;
      out_wait_us_o     <= '0;
      out_fired_count_o <= '0;
      out_is_fire_o     <= 1'b0;
      out_last_o        <= 1'b1;
      if (cmd_i.emit_final || (is_process && !best_hit_q)) begin
        out_fired_count_o <= cnt_q;
      end else if (is_process) begin
        out_event_id_o <= best_id_q;
        out_is_fire_o  <= 1'b1;
        out_last_o     <= 1'b0;
      end else if (is_create) begin
        if (best_hit_q) begin
          out_event_id_o <= next_id_q;
        end else begin
          out_status_o <= ST_FULL;
        end
      end else if (is_query) begin
        if (best_hit_q) begin
          out_wait_us_o <= wait_val;
        end else begin
          out_status_o <= ST_NONE;
        end
      end
    end
  end

  // Report status to the controller
  assign sts_o.scan_last   = (addr_q == IDX_W'(SLOTS - 1));
  assign sts_o.is_fire     = is_process && best_hit_q;
  assign sts_o.cap_reached = (cnt_q == CNT_W'(FIRE_CAP - 1));

endmodule

`default_nettype wire

[rtl/core/ptet_ctrl.sv]
// Controller state machine of the timer table: handshakes and scan sequencing.
`default_nettype none

module ptet_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [ptet_pkg::CMD_W-1:0] in_command_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output ptet_pkg::ptet_cmd_t             cmd_o,
  input  wire ptet_pkg::ptet_sts_t        sts_i
);
  import ptet_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FINAL = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   go;

  // Result register is free to take a new transaction
  assign go = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_command_i != CMD_RSVD) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (go) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.is_fire) begin
            state_d = S_IDLE;
          end else if (sts_i.cap_reached) begin
            state_d = S_FINAL;
          end else begin
            cmd_o.scan_begin = 1'b1;
            state_d          = S_SCAN;
          end
        end
      end
      S_FINAL: begin
        if (go) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the output valid until the transaction is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit || cmd_o.emit_final) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/periodic_timer_event_table_top.sv]
// Top level of the periodic timer event table.
//
// Input channel: in_valid_i / in_stall_o carry one command transaction
// (create, process due events, query). Output channel: out_valid_o /
// out_stall_i carry result transactions, one field per port.
// Every create, process or query command scans all SLOTS slots in turn
// through the slot memory read port, one slot per cycle, then passes
// S_DRAIN for the read register and delivers its result in S_EMIT; the
// next command is taken back in S_IDLE. A process command repeats the scan
// once per fired event, and a round that finds nothing due delivers the
// count result. When the sixteenth fire reaches the fire limit, the count
// result follows it from S_FINAL. Command code 3 is taken and gives no
// result. Reset clears the valid bits, the id counter and all handshake
// state; slot contents need no clearing pass. While the receiver stalls, the
// result is held in the output register and the sequencer waits before the
// next delivery; a new command is accepted while the last result still waits.
`default_nettype none

module periodic_timer_event_table_top #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [ptet_pkg::CMD_W-1:0]      in_command_i,
  input  wire logic [ptet_pkg::TIME_W-1:0]     in_now_us_i,
  input  wire logic [ptet_pkg::MS_W-1:0]       in_delay_ms_i,
  input  wire logic [ptet_pkg::MS_W-1:0]       in_period_ms_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [ptet_pkg::STATUS_W-1:0]        out_status_o,
  output logic [ptet_pkg::ID_W-1:0]            out_event_id_o,
  output logic [ptet_pkg::TIME_W-1:0]          out_wait_us_o,
  output logic [ptet_pkg::CNT_W-1:0]           out_fired_count_o,
  output logic                                 out_is_fire_o,
  output logic                                 out_last_o
);
  import ptet_pkg::*;

  ptet_cmd_t cmd;
  ptet_sts_t sts;

  // Sequence handshakes and scans
  ptet_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_command_i (in_command_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // Store slots, compare and form results
  ptet_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_command_i      (in_command_i),
    .in_now_us_i       (in_now_us_i),
    .in_delay_ms_i     (in_delay_ms_i),
    .in_period_ms_i    (in_period_ms_i),
    .out_status_o      (out_status_o),
    .out_event_id_o    (out_event_id_o),
    .out_wait_us_o     (out_wait_us_o),
    .out_fired_count_o (out_fired_count_o),
    .out_is_fire_o     (out_is_fire_o),
    .out_last_o        (out_last_o)
  );

endmodule

`default_nettype wire
